### sv/tkss_pkg.sv
package tkss_pkg;

  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;

  localparam int S_POS_LSB = 0;
  localparam int S_VAL_LSB = S_POS_LSB + POS_W;
  localparam int S_K_LSB   = S_VAL_LSB + VAL_W;
  localparam int S_TDATA_W = 56;

  localparam int M_POS_LSB = 0;
  localparam int M_SUM_LSB = M_POS_LSB + POS_W;
  localparam int M_PAD     = 3;
  localparam int M_TDATA_W = POS_W + SUM_W + M_PAD;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

endpackage

### sv/top_k_suffix_sum_tree_top.sv
// Top-k suffix sum over rank positions 1..active_size. An insert word (tuser = 0) marks a
// position occupied and stores its value; it gives no result. A query word (tuser = 1)
// returns the largest start position whose suffix holds at least k occupied entries, and the
// sum of values over that suffix. Count and sum totals live in one tree memory of 2*T nodes,
// T = SIZE rounded up to a power of two, L = log2(T), with a single read and a single write
// per cycle. An insert does a leaf read, then one read-modify-write per level up to the
// root; a query does one read per level for the prefix total up to active_size, then one
// read per level for the descent, which is skipped when k is zero or exceeds the entry
// count. A query also waits as long as an earlier result still sits unaccepted in the
// output register. After reset all 2*T memory nodes are cleared, while s_tready stays low;
// the configuration channel is always ready. A finished result waits in the output
// register while the next word is taken.
module top_k_suffix_sum_tree_top #(
  parameter int SIZE       = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: position [10:0], value [42:11], k_count [53:43], zero [55:54]
  input  logic [tkss_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: action [0]
  input  logic [0:0]                     s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: start_position [10:0], suffix_sum [52:11], zero [55:53]
  output logic [tkss_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [tkss_pkg::POS_W-1:0]     cfg_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready
);

  localparam int POSW   = tkss_pkg::POS_W;
  localparam int VALW   = tkss_pkg::VAL_W;
  localparam int SUMW   = tkss_pkg::SUM_W;
  localparam int LEVELS = $clog2(SIZE);
  localparam int AW     = LEVELS + 1;
  localparam int CW     = LEVELS + 1;
  localparam int XW     = (LEVELS + 1 > POSW) ? LEVELS + 1 : POSW;
  localparam int SW     = $clog2(LEVELS + 2);
  localparam logic [SUMW-1:0] VMASK =
    (VALUE_BITS >= SUMW) ? {SUMW{1'b1}} : ((SUMW'(1) << VALUE_BITS) - SUMW'(1));

  typedef struct packed {
    logic [CW-1:0]   cnt;
    logic [SUMW-1:0] sum;
  } node_t;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_INS  = 7'b0000100,
    ST_PRE  = 7'b0001000,
    ST_DEC  = 7'b0010000,
    ST_DESC = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  node_t mem [2**AW];
  node_t rdata;
  node_t wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic [XW-1:0]   active_size;
  logic [AW-1:0]   node;
  logic [SW-1:0]   step;
  logic [SUMW-1:0] ins_sum;
  logic            dcnt;
  logic [SUMW-1:0] dsum;
  logic [CW-1:0]   acc_cnt;
  logic [SUMW-1:0] acc_sum;
  logic [SUMW-1:0] leaf_sum;
  logic [SUMW-1:0] desc_sum;
  logic [CW-1:0]   rem;
  logic [POSW-1:0] k_reg;
  logic            rd_add_q;
  logic            rd_first_q;
  logic [XW-1:0]   res_pos;
  logic [SUMW-1:0] res_base;
  logic [POSW-1:0] out_pos;
  logic [SUMW-1:0] out_sum;

  logic [XW-1:0]   eff_n;
  logic [POSW-1:0] in_pos;
  logic [VALW-1:0] in_val;
  logic [POSW-1:0] in_k;
  logic [XW-1:0]   pos_x;
  logic            pos_ok;
  logic            s_acc;
  logic            pre_add;
  logic            pre_first;
  logic            go_right;
  logic [AW-1:0]   new_node;
  logic [XW-1:0]   k_x;
  logic [XW-1:0]   p_x;
  logic            out_free;

  function automatic logic [AW-1:0] leaf_addr(input logic [XW-1:0] p);
    logic [XW-1:0] pm1;
    pm1 = p - XW'(1);
    return {1'b1, pm1[LEVELS-1:0]};
  endfunction

  assign in_pos    = s_tdata[tkss_pkg::S_POS_LSB +: POSW];
  assign in_val    = s_tdata[tkss_pkg::S_VAL_LSB +: VALW];
  assign in_k      = s_tdata[tkss_pkg::S_K_LSB +: POSW];
  assign pos_x     = XW'(in_pos);
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{tkss_pkg::M_PAD{1'b0}}, out_sum, out_pos};
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (active_size == '0) begin
      eff_n = XW'(1);
    end else if (active_size > XW'(SIZE)) begin
      eff_n = XW'(SIZE);
    end else begin
      eff_n = active_size;
    end
  end

  assign pos_ok   = (pos_x != '0) && (pos_x <= eff_n);
  assign go_right = rdata.cnt < rem;
  assign new_node = {node[AW-2:0], go_right};
  assign k_x      = XW'(k_reg);
  assign p_x      = XW'(acc_cnt);

  always_comb begin
    raddr     = '0;
    we        = 1'b0;
    waddr     = node;
    wdata     = '0;
    pre_add   = 1'b0;
    pre_first = 1'b0;
    unique case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      ST_IDLE: begin
        raddr = leaf_addr(pos_x);
      end
      ST_INS: begin
        we    = 1'b1;
        raddr = node >> 1;
        if (step == '0) begin
          wdata.cnt = CW'(1);
          wdata.sum = ins_sum;
        end else begin
          wdata.cnt = rdata.cnt + CW'(dcnt);
          wdata.sum = rdata.sum + dsum;
        end
      end
      ST_PRE: begin
        if (step == '0) begin
          raddr     = node;
          pre_add   = 1'b1;
          pre_first = 1'b1;
        end else if (step <= SW'(LEVELS)) begin
          raddr   = node ^ AW'(1);
          pre_add = node[0];
        end
      end
      ST_DEC: begin
        raddr = AW'(2);
      end
      ST_DESC: begin
        raddr = {new_node[AW-2:0], 1'b0};
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      clr_addr    <= '0;
      active_size <= XW'(SIZE);
      m_tvalid    <= 1'b0;
      rd_add_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      step        <= '0;
    end else begin
      rd_add_q   <= pre_add;
      rd_first_q <= pre_first;
      if (cfg_valid) begin
        active_size <= XW'(cfg_data);
      end
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_acc) begin
            step <= '0;
            if (s_tuser[0] == tkss_pkg::ACT_QUERY) begin
              k_reg   <= in_k;
              node    <= leaf_addr(eff_n);
              acc_cnt <= '0;
              acc_sum <= '0;
              state   <= ST_PRE;
            end else if (pos_ok) begin
              node    <= leaf_addr(pos_x);
              ins_sum <= SUMW'(in_val) & VMASK;
              state   <= ST_INS;
            end
          end
        end
        ST_INS: begin
          if (step == '0) begin
            dcnt <= (rdata.cnt == '0);
            dsum <= ins_sum - rdata.sum;
            step <= SW'(1);
          end
          node <= node >> 1;
          if (node == AW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_PRE: begin
          if (rd_add_q) begin
            acc_cnt <= acc_cnt + rdata.cnt;
            acc_sum <= acc_sum + rdata.sum;
          end
          if (rd_first_q) begin
            leaf_sum <= rdata.sum;
          end
          if (step != '0 && step <= SW'(LEVELS)) begin
            node <= node >> 1;
          end
          if (step == SW'(LEVELS + 1)) begin
            state <= ST_DEC;
          end else begin
            step <= step + SW'(1);
          end
        end
        ST_DEC: begin
          desc_sum <= '0;
          priority if (k_x == '0) begin
            res_pos  <= eff_n;
            res_base <= leaf_sum;
            state    <= ST_FIN;
          end else if (k_x > p_x) begin
            res_pos  <= XW'(1);
            res_base <= acc_sum;
            state    <= ST_FIN;
          end else begin
            rem   <= CW'(p_x - k_x + XW'(1));
            node  <= AW'(1);
            step  <= '0;
            state <= ST_DESC;
          end
        end
        ST_DESC: begin
          if (go_right) begin
            rem      <= rem - rdata.cnt;
            desc_sum <= desc_sum + rdata.sum;
          end
          node <= new_node;
          if (step == SW'(LEVELS - 1)) begin
            res_pos  <= XW'(new_node[LEVELS-1:0]) + XW'(1);
            res_base <= acc_sum;
            state    <= ST_FIN;
          end else begin
            step <= step + SW'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_pos <= res_pos[POSW-1:0];
      out_sum <= res_base - desc_sum;
    end
  end

endmodule

### sv/tkss_checker.sv
module tkss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [tkss_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [0:0]                     s_tuser,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [tkss_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // block input during the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // start position is never zero
  a_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[tkss_pkg::M_POS_LSB +: tkss_pkg::POS_W] != '0)
    else $error("start position of zero");

  // a query holds off the next word
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == tkss_pkg::ACT_QUERY) |=> !s_tready)
    else $error("input ready right after a query word");

endmodule

bind top_k_suffix_sum_tree_top tkss_checker u_tkss_checker (.*);
